@@ rtl/hsf_pkg.sv @@
// Shared constants, types and helpers of the Horn-Schunck flow engine.
package hsf_pkg;

  localparam int MAX_WIDTH        = 64;
  localparam int MAX_HEIGHT       = 64;
  localparam int FLOW_FRAC_BITS   = 8;
  localparam int WEIGHT_FRAC_BITS = 8;

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int TOTAL_W = ADDR_W + 1;
  localparam int DIM_W   = 7;
  localparam int PIX_W   = 8;
  localparam int FLOW_W  = 24;
  localparam int WEIGHT_W = 24;
  localparam int ITER_W  = 8;
  localparam int IDX_W   = 12;

  localparam int GRAD_W  = PIX_W + 3;
  localparam int SUM_W   = FLOW_W + 2;
  localparam int PROD_W  = GRAD_W + FLOW_W;
  localparam int P_W     = PROD_W + 2;
  localparam int XP_W    = GRAD_W + P_W;
  localparam int SQ_W    = 2 * GRAD_W - 1;
  localparam int NUM_W   = XP_W + WEIGHT_FRAC_BITS;
  localparam int DEN_W   = SQ_W + WEIGHT_FRAC_BITS + 2;
  localparam int DIFF_W  = NUM_W + 2;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_SMOOTHNESS   = 4'd2,
    REG_ITERATIONS   = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [FLOW_W-1:0] sat_flow(input logic signed [DIFF_W-1:0] x);
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] lo;
    hi = {{(DIFF_W-FLOW_W+1){1'b0}}, {(FLOW_W-1){1'b1}}};
    lo = {{(DIFF_W-FLOW_W+1){1'b1}}, {(FLOW_W-1){1'b0}}};
    if (x > hi) return hi[FLOW_W-1:0];
    else if (x < lo) return lo[FLOW_W-1:0];
    else return x[FLOW_W-1:0];
  endfunction

endpackage

@@ rtl/horn_schunck_flow_engine_unit.sv @@
// Horn-Schunck optical flow engine: frame load, Jacobi passes and flow readout.
// Load requests store one pixel pair per cycle while the engine is idle. The request that
// completes a frame starts iteration_count Jacobi passes; during them no request is taken.
// Each pass works through every pixel in turn: two pixel/flow memory read steps, the
// gradient stage, two runs of the shared 56-step divider (neighbour average, then the
// correction), three multiply and add stages and the write-back. With a zero denominator
// the correction divide is skipped. A read request passes through the flow memory read
// register into the output register. Flow is kept in two banks of one memory and
// alternates between them per pass; the first pass takes the previous flow as zero, so no
// clearing pass is needed.
module horn_schunck_flow_engine_unit import hsf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     req_type,
  input  logic [PIX_W-1:0]         pixel_first,
  input  logic [PIX_W-1:0]         pixel_second,
  input  logic [IDX_W-1:0]         read_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [FLOW_W-1:0] flow_u,
  output logic signed [FLOW_W-1:0] flow_v,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [WEIGHT_W-1:0]      cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDOUT, S_RD0, S_RD1, S_GRAD, S_AVG_GO, S_AVG_WAIT,
    S_MUL, S_SUM, S_XP, S_COR_GO, S_COR_WAIT, S_WR
  } state_t;

  localparam int FADDR_W = ADDR_W + 1;
  localparam int FWORD_W = 2 * FLOW_W;
  localparam int PWORD_W = 2 * PIX_W;

  state_t state;

  logic [DIM_W-1:0]    frame_width, frame_height;
  logic [WEIGHT_W-1:0] smoothness_weight;
  logic [ITER_W-1:0]   iteration_count;

  logic [DIM_W-1:0]   act_w, act_h;
  logic [TOTAL_W-1:0] total;
  logic               in_acc, load_acc, read_acc, load_end;
  logic [ADDR_W-1:0]  load_pos;

  // pixel memory, {first, second}
  logic [PWORD_W-1:0] pix_mem [DEPTH];
  logic [PWORD_W-1:0] pix_qa, pix_qb;
  logic [ADDR_W-1:0]  pix_ra, pix_rb;
  logic               pix_re;

  // flow memory, two banks of {u, v}
  logic [FWORD_W-1:0] flow_mem [2*DEPTH];
  logic [FWORD_W-1:0] flow_qa, flow_qb;
  logic [FADDR_W-1:0] flow_ra, flow_rb, flow_wa;
  logic               flow_re, flow_we;

  logic [DIM_W-1:0]    run_w, run_h;
  logic [WEIGHT_W-1:0] run_sw;
  logic [ITER_W-1:0]   run_iter, pass;
  logic [TOTAL_W-1:0]  run_total;
  logic                rd_bank, flow_zero, rd_zero;
  logic [DIM_W-1:0]    x, y;
  logic [ADDR_W-1:0]   idx, yrow, ym_row, xm;

  logic [PWORD_W-1:0] pa, pb;
  logic [FWORD_W-1:0] nb_up, nb_dn;

  logic signed [GRAD_W-1:0] ix, iy, it, ix_n, iy_n, it_n;
  logic signed [GRAD_W-1:0] ga, gb, gc, ge, f_sum, s_sum;
  logic signed [SUM_W-1:0]  su, sv, su_n, sv_n;
  logic [2:0]               n, n_n;
  logic                     has_up, has_dn, has_lf, has_rt, prev_ok;
  logic signed [FLOW_W-1:0] up_u, up_v, dn_u, dn_v, lf_u, lf_v, rt_u, rt_v;

  logic [SUM_W-1:0]         su_mag, sv_mag;
  logic signed [FLOW_W:0]   qa_s, qb_s, ua_w, va_w;
  logic signed [FLOW_W-1:0] ua, va, res_u, res_v;
  logic signed [PROD_W-1:0] mu, mv;
  logic [SQ_W-1:0]          sq;
  logic signed [P_W-1:0]    p;
  logic [DEN_W-2:0]         d;
  logic signed [XP_W-1:0]   xu, xv;
  logic [XP_W-1:0]          xu_mag, xv_mag;
  logic signed [DIFF_W-1:0] ua_x, va_x, qu_x, qv_x, cor_u_w, cor_v_w;

  logic             div_start;
  logic [NUM_W-1:0] div_na, div_nb, quo_a, quo_b;
  logic [DEN_W-1:0] div_den;
  div_stat_t        div_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= DIM_W'(64);
      frame_height      <= DIM_W'(64);
      smoothness_weight <= WEIGHT_W'(256);
      iteration_count   <= ITER_W'(8);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width       <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height      <= cfg_data[DIM_W-1:0];
        REG_SMOOTHNESS:   smoothness_weight <= cfg_data;
        REG_ITERATIONS:   iteration_count   <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    act_w = (frame_width < DIM_W'(2)) ? DIM_W'(2) :
            (frame_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width;
    act_h = (frame_height < DIM_W'(2)) ? DIM_W'(2) :
            (frame_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height;
    total = TOTAL_W'(act_w) * TOTAL_W'(act_h);
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_acc = in_acc && !req_type;
  assign read_acc = in_acc && req_type;
  assign load_end = (TOTAL_W'(load_pos) + TOTAL_W'(1)) >= total;

  // addressing
  always_comb begin
    ym_row = (y == '0) ? ADDR_W'(run_w) : yrow - ADDR_W'(run_w);
    xm     = (x == '0) ? ADDR_W'(1) : ADDR_W'(x) - ADDR_W'(1);
    pix_re = (state == S_RD0) || (state == S_RD1);
    pix_ra = (state == S_RD0) ? ym_row + xm : yrow + xm;
    pix_rb = (state == S_RD0) ? ym_row + ADDR_W'(x) : idx;
    flow_re = read_acc || pix_re;
    case (state)
      S_RD0: begin
        flow_ra = {~pass[0], idx - ADDR_W'(run_w)};
        flow_rb = {~pass[0], idx + ADDR_W'(run_w)};
      end
      S_RD1: begin
        flow_ra = {~pass[0], idx - ADDR_W'(1)};
        flow_rb = {~pass[0], idx + ADDR_W'(1)};
      end
      default: begin
        flow_ra = {rd_bank, read_index};
        flow_rb = {rd_bank, read_index};
      end
    endcase
    flow_we = (state == S_WR);
    flow_wa = {pass[0], idx};
  end

  always_ff @(posedge clk) begin
    if (load_acc) pix_mem[load_pos] <= {pixel_first, pixel_second};
    if (pix_re) begin
      pix_qa <= pix_mem[pix_ra];
      pix_qb <= pix_mem[pix_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (flow_we) flow_mem[flow_wa] <= {res_u, res_v};
    if (flow_re) begin
      flow_qa <= flow_mem[flow_ra];
      flow_qb <= flow_mem[flow_rb];
    end
  end

  // gradients and neighbour sums
  always_comb begin
    ga    = GRAD_W'(pa[PWORD_W-1:PIX_W]) + GRAD_W'(pa[PIX_W-1:0]);
    gb    = GRAD_W'(pb[PWORD_W-1:PIX_W]) + GRAD_W'(pb[PIX_W-1:0]);
    gc    = GRAD_W'(pix_qa[PWORD_W-1:PIX_W]) + GRAD_W'(pix_qa[PIX_W-1:0]);
    ge    = GRAD_W'(pix_qb[PWORD_W-1:PIX_W]) + GRAD_W'(pix_qb[PIX_W-1:0]);
    f_sum = GRAD_W'(pa[PWORD_W-1:PIX_W]) + GRAD_W'(pb[PWORD_W-1:PIX_W])
          + GRAD_W'(pix_qa[PWORD_W-1:PIX_W]) + GRAD_W'(pix_qb[PWORD_W-1:PIX_W]);
    s_sum = GRAD_W'(pa[PIX_W-1:0]) + GRAD_W'(pb[PIX_W-1:0])
          + GRAD_W'(pix_qa[PIX_W-1:0]) + GRAD_W'(pix_qb[PIX_W-1:0]);
    ix_n  = gb + ge - ga - gc;
    iy_n  = gc + ge - ga - gb;
    it_n  = s_sum - f_sum;

    prev_ok = (pass != '0);
    has_up  = (y != '0);
    has_dn  = (y + DIM_W'(1)) < run_h;
    has_lf  = (x != '0);
    has_rt  = (x + DIM_W'(1)) < run_w;
    up_u = nb_up[FWORD_W-1:FLOW_W];   up_v = nb_up[FLOW_W-1:0];
    dn_u = nb_dn[FWORD_W-1:FLOW_W];   dn_v = nb_dn[FLOW_W-1:0];
    lf_u = flow_qa[FWORD_W-1:FLOW_W]; lf_v = flow_qa[FLOW_W-1:0];
    rt_u = flow_qb[FWORD_W-1:FLOW_W]; rt_v = flow_qb[FLOW_W-1:0];
    su_n = ((has_up && prev_ok) ? SUM_W'(up_u) : SUM_W'(0))
         + ((has_dn && prev_ok) ? SUM_W'(dn_u) : SUM_W'(0))
         + ((has_lf && prev_ok) ? SUM_W'(lf_u) : SUM_W'(0))
         + ((has_rt && prev_ok) ? SUM_W'(rt_u) : SUM_W'(0));
    sv_n = ((has_up && prev_ok) ? SUM_W'(up_v) : SUM_W'(0))
         + ((has_dn && prev_ok) ? SUM_W'(dn_v) : SUM_W'(0))
         + ((has_lf && prev_ok) ? SUM_W'(lf_v) : SUM_W'(0))
         + ((has_rt && prev_ok) ? SUM_W'(rt_v) : SUM_W'(0));
    n_n  = {2'b00, has_up} + {2'b00, has_dn} + {2'b00, has_lf} + {2'b00, has_rt};
  end

  // divider operands and rounding
  always_comb begin
    su_mag = su[SUM_W-1] ? SUM_W'(-su) : SUM_W'(su);
    sv_mag = sv[SUM_W-1] ? SUM_W'(-sv) : SUM_W'(sv);
    xu_mag = xu[XP_W-1] ? XP_W'(-xu) : XP_W'(xu);
    xv_mag = xv[XP_W-1] ? XP_W'(-xv) : XP_W'(xv);
    if (state == S_AVG_GO) begin
      div_na  = NUM_W'({su_mag, 1'b0}) + NUM_W'(n);
      div_nb  = NUM_W'({sv_mag, 1'b0}) + NUM_W'(n);
      div_den = DEN_W'({n, 1'b0});
    end else begin
      div_na  = NUM_W'({xu_mag, {(WEIGHT_FRAC_BITS+1){1'b0}}}) + NUM_W'(d);
      div_nb  = NUM_W'({xv_mag, {(WEIGHT_FRAC_BITS+1){1'b0}}}) + NUM_W'(d);
      div_den = {d, 1'b0};
    end
    div_start = (state == S_AVG_GO) || ((state == S_COR_GO) && (d != '0));

    qa_s = quo_a[FLOW_W:0];
    qb_s = quo_b[FLOW_W:0];
    ua_w = su[SUM_W-1] ? -qa_s : qa_s;
    va_w = sv[SUM_W-1] ? -qb_s : qb_s;

    ua_x = DIFF_W'(ua);
    va_x = DIFF_W'(va);
    qu_x = {2'b00, quo_a};
    qv_x = {2'b00, quo_b};
    cor_u_w = xu[XP_W-1] ? ua_x + qu_x : ua_x - qu_x;
    cor_v_w = xv[XP_W-1] ? va_x + qv_x : va_x - qv_x;
  end

  hsf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_a (div_na),
    .num_b (div_nb),
    .den   (div_den),
    .stat  (div_stat),
    .quo_a (quo_a),
    .quo_b (quo_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      load_pos  <= '0;
      flow_zero <= 1'b1;
      rd_bank   <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_RDOUT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (read_acc) begin
            rd_zero <= !((TOTAL_W'(read_index) < total) && (TOTAL_W'(read_index) < run_total)
                         && !flow_zero);
            state   <= S_RDOUT;
          end else if (load_acc) begin
            if (load_end) begin
              load_pos  <= '0;
              run_w     <= act_w;
              run_h     <= act_h;
              run_sw    <= smoothness_weight;
              run_iter  <= iteration_count;
              run_total <= total;
              x         <= '0;
              y         <= '0;
              idx       <= '0;
              yrow      <= '0;
              pass      <= '0;
              if (iteration_count == '0) flow_zero <= 1'b1;
              else state <= S_RD0;
            end else begin
              load_pos <= load_pos + ADDR_W'(1);
            end
          end
        end
        S_RDOUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            flow_u    <= rd_zero ? '0 : flow_qa[FWORD_W-1:FLOW_W];
            flow_v    <= rd_zero ? '0 : flow_qa[FLOW_W-1:0];
            state     <= S_IDLE;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          pa    <= pix_qa;
          pb    <= pix_qb;
          nb_up <= flow_qa;
          nb_dn <= flow_qb;
          state <= S_GRAD;
        end
        S_GRAD: begin
          ix    <= ix_n;
          iy    <= iy_n;
          it    <= it_n;
          su    <= su_n;
          sv    <= sv_n;
          n     <= n_n;
          state <= S_AVG_GO;
        end
        S_AVG_GO: state <= S_AVG_WAIT;
        S_AVG_WAIT: begin
          if (div_stat.done) begin
            ua    <= ua_w[FLOW_W-1:0];
            va    <= va_w[FLOW_W-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mu    <= ix * ua;
          mv    <= iy * va;
          sq    <= ix * ix + iy * iy;
          state <= S_SUM;
        end
        S_SUM: begin
          p     <= P_W'(mu) + P_W'(mv) + (P_W'(it) <<< FLOW_FRAC_BITS);
          d     <= (DEN_W-1)'(run_sw) + ((DEN_W-1)'(sq) << WEIGHT_FRAC_BITS);
          state <= S_XP;
        end
        S_XP: begin
          xu    <= ix * p;
          xv    <= iy * p;
          state <= S_COR_GO;
        end
        S_COR_GO: begin
          if (d == '0) begin
            res_u <= ua;
            res_v <= va;
            state <= S_WR;
          end else begin
            state <= S_COR_WAIT;
          end
        end
        S_COR_WAIT: begin
          if (div_stat.done) begin
            res_u <= sat_flow(cor_u_w);
            res_v <= sat_flow(cor_v_w);
            state <= S_WR;
          end
        end
        S_WR: begin
          idx   <= idx + ADDR_W'(1);
          state <= S_RD0;
          if ((x + DIM_W'(1)) == run_w) begin
            x <= '0;
            if ((y + DIM_W'(1)) == run_h) begin
              y    <= '0;
              yrow <= '0;
              idx  <= '0;
              if ((pass + ITER_W'(1)) == run_iter) begin
                rd_bank   <= pass[0];
                flow_zero <= 1'b0;
                state     <= S_IDLE;
              end else begin
                pass <= pass + ITER_W'(1);
              end
            end else begin
              y    <= y + DIM_W'(1);
              yrow <= yrow + ADDR_W'(run_w);
            end
          end else begin
            x <= x + DIM_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_wr_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> !div_stat.busy)
    else $error("flow write while divider still busy");

  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RDOUT))
    else $error("result raised outside read request");

  a_cor_nonzero_den: assert property (@(posedge clk) disable iff (rst)
    ((state == S_COR_WAIT) && div_stat.done) |-> (d != '0))
    else $error("correction divide with zero denominator");

endmodule

@@ rtl/hsf_div.sv @@
// Two-lane restoring divider sharing one divisor, one quotient bit per lane per cycle while busy.
module hsf_div import hsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num_a,
  input  logic [NUM_W-1:0] num_b,
  input  logic [DEN_W-1:0] den,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quo_a,
  output logic [NUM_W-1:0] quo_b
);

  logic [NUM_W-1:0] nq_a, nq_b;
  logic [DEN_W-1:0] rem_a, rem_b, den_q;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   sh_a, sh_b, dext;
  logic             fit_a, fit_b;

  always_comb begin
    dext  = {1'b0, den_q};
    sh_a  = {rem_a, nq_a[NUM_W-1]};
    sh_b  = {rem_b, nq_b[NUM_W-1]};
    fit_a = sh_a >= dext;
    fit_b = sh_b >= dext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(NUM_W);
        nq_a      <= num_a;
        nq_b      <= num_b;
        rem_a     <= '0;
        rem_b     <= '0;
        den_q     <= den;
      end else if (stat.busy) begin
        nq_a  <= {nq_a[NUM_W-2:0], fit_a};
        nq_b  <= {nq_b[NUM_W-2:0], fit_b};
        rem_a <= fit_a ? DEN_W'(sh_a - dext) : sh_a[DEN_W-1:0];
        rem_b <= fit_b ? DEN_W'(sh_b - dext) : sh_b[DEN_W-1:0];
        cnt   <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  assign quo_a = nq_a;
  assign quo_b = nq_b;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the Horn-Schunck flow engine: frame loads, flow reads, config.
module testbench;
  import hsf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [PIX_W-1:0] pixel_first = '0;
  logic [PIX_W-1:0] pixel_second = '0;
  logic [IDX_W-1:0] read_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FLOW_W-1:0] flow_u;
  logic signed [FLOW_W-1:0] flow_v;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0] cfg_data = '0;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  horn_schunck_flow_engine_unit u_dut (.*);

  always #5 clk = ~clk;

  // predicted engine state
  int unsigned cur_width, cur_height, cur_weight, cur_iters, load_pos;
  logic [7:0] frame_a [DEPTH];
  logic [7:0] frame_b [DEPTH];
  longint flow_u_now [DEPTH];
  longint flow_v_now [DEPTH];
  longint flow_u_old [DEPTH];
  longint flow_v_old [DEPTH];
  longint grad_x [DEPTH];
  longint grad_y [DEPTH];
  longint grad_t [DEPTH];

  logic signed [FLOW_W-1:0] pending_u [$];
  logic signed [FLOW_W-1:0] pending_v [$];
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;

  function automatic int unsigned clamp_dim(int unsigned d, int unsigned hi);
    if (d < 2) return 2;
    if (d > hi) return hi;
    return d;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (2 * m + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip_flow(longint x);
    if (x > 64'sd8388607) return 64'sd8388607;
    if (x < -64'sd8388608) return -64'sd8388608;
    return x;
  endfunction

  task automatic solve_flow();
    int unsigned w, h, ym, xm, ia, ib, ic, ie, i;
    longint a, b, c, e, su, sv, n, ua, va, ix, iy, p, d;
    w = clamp_dim(cur_width, MAX_WIDTH);
    h = clamp_dim(cur_height, MAX_HEIGHT);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        ym = (y != 0) ? y - 1 : 1;
        xm = (x != 0) ? x - 1 : 1;
        ia = ym * w + xm; ib = ym * w + x; ic = y * w + xm; ie = y * w + x;
        a = frame_a[ia] + frame_b[ia];
        b = frame_a[ib] + frame_b[ib];
        c = frame_a[ic] + frame_b[ic];
        e = frame_a[ie] + frame_b[ie];
        grad_x[ie] = -a + b - c + e;
        grad_y[ie] = -a - b + c + e;
        grad_t[ie] = (longint'(frame_b[ia]) + frame_b[ib] + frame_b[ic] + frame_b[ie])
                   - (longint'(frame_a[ia]) + frame_a[ib] + frame_a[ic] + frame_a[ie]);
      end
    for (int j = 0; j < DEPTH; j++) begin
      flow_u_now[j] = 0; flow_v_now[j] = 0;
    end
    for (int k = 0; k < cur_iters; k++) begin
      flow_u_old = flow_u_now;
      flow_v_old = flow_v_now;
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          i = y * w + x;
          su = 0; sv = 0; n = 0;
          if (y > 0) begin su += flow_u_old[i-w]; sv += flow_v_old[i-w]; n++; end
          if (y + 1 < h) begin su += flow_u_old[i+w]; sv += flow_v_old[i+w]; n++; end
          if (x > 0) begin su += flow_u_old[i-1]; sv += flow_v_old[i-1]; n++; end
          if (x + 1 < w) begin su += flow_u_old[i+1]; sv += flow_v_old[i+1]; n++; end
          ua = round_div(su, n);
          va = round_div(sv, n);
          ix = grad_x[i];
          iy = grad_y[i];
          p = ix * ua + iy * va + grad_t[i] * (64'sd1 <<< FLOW_FRAC_BITS);
          d = longint'(cur_weight) + (ix * ix + iy * iy) * 256;
          if (d == 0) begin
            flow_u_now[i] = clip_flow(ua);
            flow_v_now[i] = clip_flow(va);
          end else begin
            flow_u_now[i] = clip_flow(ua - round_div(ix * p * 256, d));
            flow_v_now[i] = clip_flow(va - round_div(iy * p * 256, d));
          end
        end
    end
  endtask

  task automatic accept_request(logic kind, logic [7:0] pa, logic [7:0] pb,
                                logic [IDX_W-1:0] idx);
    int unsigned total;
    logic signed [FLOW_W-1:0] eu, ev;
    total = clamp_dim(cur_width, MAX_WIDTH) * clamp_dim(cur_height, MAX_HEIGHT);
    if (kind == REQ_LOAD) begin
      if (load_pos < DEPTH) begin
        frame_a[load_pos] = pa;
        frame_b[load_pos] = pb;
      end
      if (load_pos + 1 >= total) begin
        solve_flow();
        load_pos = 0;
      end else load_pos++;
    end else begin
      eu = '0;
      ev = '0;
      if (idx < total) begin
        eu = flow_u_now[idx][FLOW_W-1:0];
        ev = flow_v_now[idx][FLOW_W-1:0];
      end
      pending_u = {pending_u, eu};
      pending_v = {pending_v, ev};
    end
  endtask

  // one request; sender sends in bursts with random idle gaps between them
  task automatic send_request(logic kind, logic [7:0] pa, logic [7:0] pb,
                              logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= kind;
    pixel_first <= pa;
    pixel_second <= pb;
    read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accept_request(kind, pa, pb, idx);
    items_sent++;
  endtask

  task automatic load_pixel(logic [7:0] pa, logic [7:0] pb);
    send_request(REQ_LOAD, pa, pb, IDX_W'($urandom_range(0, 4095)));
  endtask

  task automatic read_flow(logic [IDX_W-1:0] idx);
    send_request(REQ_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), idx);
  endtask

  // wait for all results and for the engine to go idle
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_u.size() != 0 || !in_ready) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [WEIGHT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (r)
      REG_FRAME_WIDTH:  cur_width = value & 24'h7F;
      REG_FRAME_HEIGHT: cur_height = value & 24'h7F;
      REG_SMOOTHNESS:   cur_weight = value;
      REG_ITERATIONS:   cur_iters = value & 24'hFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(int w, int h, int weight, int iters);
    write_reg(REG_FRAME_WIDTH, WEIGHT_W'(w));
    write_reg(REG_FRAME_HEIGHT, WEIGHT_W'(h));
    write_reg(REG_SMOOTHNESS, WEIGHT_W'(weight));
    write_reg(REG_ITERATIONS, WEIGHT_W'(iters));
  endtask

  // pattern: 0 random, 1 uniform, 2 shifted ramp, 3 extremes
  task automatic load_frame(int pattern);
    int unsigned total, w;
    logic [7:0] pa, pb;
    w = clamp_dim(cur_width, MAX_WIDTH);
    total = w * clamp_dim(cur_height, MAX_HEIGHT);
    for (int i = 0; i < total; i++) begin
      case (pattern)
        1: begin pa = 8'd77; pb = 8'd77; end
        2: begin pa = 8'((i % w) * 37 + (i / w) * 11); pb = pa + 8'd9; end
        3: begin pa = (i % 2) ? 8'hFF : 8'h00; pb = ~pa; end
        default: begin pa = 8'($urandom_range(0, 255)); pb = 8'($urandom_range(0, 255)); end
      endcase
      load_pixel(pa, pb);
    end
  endtask

  task automatic read_all(int extra);
    int unsigned total;
    total = clamp_dim(cur_width, MAX_WIDTH) * clamp_dim(cur_height, MAX_HEIGHT);
    for (int i = 0; i < total; i++) read_flow(IDX_W'(i));
    for (int i = 0; i < extra; i++) read_flow(IDX_W'($urandom_range(total, 4095)));
  endtask

  task automatic test_read_after_reset();
    read_flow(IDX_W'(0));
    read_flow(12'hFFF);
    drain();
  endtask

  task automatic test_extreme_pixels();
    set_geometry(2, 2, 24'hFFFFFF, 1);
    load_frame(3);
    read_all(1);
    drain();
    set_geometry(3, 2, 1, 2);
    load_frame(2);
    read_all(1);
    drain();
  endtask

  task automatic test_zero_denominator();
    set_geometry(2, 3, 0, 3);
    load_frame(1);
    read_all(1);
    drain();
  endtask

  task automatic test_no_iterations();
    set_geometry(2, 2, 256, 0);
    load_frame(0);
    read_all(1);
    drain();
  endtask

  task automatic test_many_iterations();
    set_geometry(2, 2, 3, 255);
    load_frame(0);
    read_all(1);
    drain();
  endtask

  task automatic test_clamped_geometry();
    set_geometry(0, 1, 512, 1);
    load_frame(0);
    read_all(2);
    drain();
    set_geometry(127, 1, 128, 1);
    load_frame(0);
    read_flow(IDX_W'(0)); read_flow(IDX_W'(127)); read_flow(IDX_W'(128));
    read_flow(IDX_W'(4095));
    drain();
    set_geometry(2, 127, 128, 1);
    load_frame(2);
    read_flow(IDX_W'(0)); read_flow(IDX_W'(127)); read_flow(IDX_W'(128));
    drain();
  endtask

  task automatic test_shrink_mid_frame();
    set_geometry(4, 4, 300, 2);
    for (int i = 0; i < 10; i++)
      load_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    drain();
    write_reg(REG_FRAME_WIDTH, WEIGHT_W'(2));
    write_reg(REG_FRAME_HEIGHT, WEIGHT_W'(2));
    load_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    read_all(1);
    drain();
  endtask

  task automatic test_random_frames();
    int w, h, total, reads;
    while (items_sent < 1900) begin
      w = $urandom_range(2, 5);
      h = $urandom_range(2, 5);
      set_geometry(w, h, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                   : $urandom_range(0, 4096), $urandom_range(1, 3));
      total = w * h;
      for (int i = 0; i < total; i++) begin
        if ($urandom_range(0, 15) == 0) read_flow(IDX_W'($urandom_range(0, 4095)));
        load_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      reads = $urandom_range(10, 40);
      for (int i = 0; i < reads; i++)
        read_flow(IDX_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                         : $urandom_range(0, total - 1)));
      drain();
    end
  endtask

  // receiver stall pattern: rotating stretches of no stall, of random stall and of periodic stall
  int stall_tick = 0;
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if ((stall_tick / 300) % 3 == 0) out_ready <= 1'b1;
    else if ((stall_tick / 300) % 3 == 1) out_ready <= ($urandom_range(0, 2) != 0);
    else out_ready <= (stall_tick % 7) < 2;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_u.size() == 0) begin
        $display("%0t: unexpected flow result u=%0d v=%0d", $time, flow_u, flow_v);
        errors++;
      end else begin
        if (flow_u !== pending_u[0]) begin
          $display("%0t: flow_u expected %0d actual %0d", $time, pending_u[0], flow_u);
          errors++;
        end
        if (flow_v !== pending_v[0]) begin
          $display("%0t: flow_v expected %0d actual %0d", $time, pending_v[0], flow_v);
          errors++;
        end
        void'(pending_u.pop_front());
        void'(pending_v.pop_front());
      end
    end
  end

  initial begin
    cur_width = 64; cur_height = 64; cur_weight = 256; cur_iters = 8; load_pos = 0;
    for (int j = 0; j < DEPTH; j++) begin
      frame_a[j] = 0; frame_b[j] = 0;
      flow_u_now[j] = 0; flow_v_now[j] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_read_after_reset();
    test_extreme_pixels();
    test_zero_denominator();
    test_no_iterations();
    test_many_iterations();
    test_clamped_geometry();
    test_shrink_mid_frame();
    test_random_frames();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_u.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hsf_pkg.sv
rtl/hsf_div.sv
rtl/horn_schunck_flow_engine_unit.sv
test/testbench.sv
